>>> rtl/core/wbss_pkg.sv
// Package for the wildcard byte signature scanner.
// Holds field widths, configuration register indexes and the types shared by
// the cells, the result buffer and the top level. Depends on nothing.
package wbss_pkg;

	localparam int BYTE_BITS       = 8;
	localparam int CFG_INDEX_BITS  = 8;
	localparam int CFG_DATA_BITS   = 64;
	localparam int MASK_BITS       = 16;
	localparam int LENGTH_BITS     = 5;
	localparam int SIG_BYTES       = 16;
	localparam int SIG_INDEX_BITS  = 4;
	localparam int OFFSET_OUT_BITS = 32;

	// Configuration register indexes.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_LOW  = 8'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_PATTERN_HIGH = 8'd1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_CARE_MASK    = 8'd2;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_LENGTH       = 8'd3;

	// Compare setting handed to one window cell.
	typedef struct packed {
		logic                 in_use;
		logic                 care;
		logic [BYTE_BITS-1:0] expected;
	} cell_cfg_t;

	// One result item.
	typedef struct packed {
		logic                       found;
		logic [OFFSET_OUT_BITS-1:0] offset;
	} result_t;

endpackage

>>> rtl/core/wbss_cell.sv
// One cell of the sliding byte window.
// Holds one window byte, hands it on to the next cell and compares the byte it
// takes in against its signature byte. Depends on wbss_pkg.
module wbss_cell
	import wbss_pkg::*;
(
	input  logic                 clk,
	input  logic                 shift_en,
	input  logic [BYTE_BITS-1:0] shift_in,
	input  cell_cfg_t            setting,
	output logic [BYTE_BITS-1:0] shift_out,
	output logic                 hit
);

	logic [BYTE_BITS-1:0] byte_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			byte_q <= shift_in;
		end
	end

	assign shift_out = byte_q;

	// The compare looks at the byte entering the cell, i.e. the window as it
	// stands once the current request has been taken in.
	assign hit = !(setting.in_use && setting.care && (shift_in != setting.expected));

endmodule

>>> rtl/core/wbss_out_buf.sv
// Two-entry result buffer: an output register and a skid register.
// Lets the scanner keep taking bytes while one result waits. Depends on wbss_pkg.
module wbss_out_buf
	import wbss_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t push_data,
	output logic    has_space,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t out_data
);

	logic    main_valid_q;
	logic    skid_valid_q;
	result_t main_q;
	result_t skid_q;
	logic    pop;

	assign pop       = main_valid_q && out_ready;
	assign has_space = !skid_valid_q;
	assign out_valid = main_valid_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (pop) begin
			if (skid_valid_q) begin
				skid_valid_q <= 1'b0;
			end else if (!push) begin
				main_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_valid_q <= 1'b1;
			end else begin
				main_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_valid_q) begin
				main_q <= skid_q;
			end else if (push) begin
				main_q <= push_data;
			end
		end else if (push) begin
			if (main_valid_q) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

>>> rtl/core/wildcard_byte_signature_scan_unit.sv
// Top level of the wildcard byte signature scanner.
// Instantiates the window cells (wbss_cell) and the result buffer (wbss_out_buf);
// depends on wbss_pkg.
//
// Usage. Bytes of a region arrive on the input channel (in_valid / in_ready,
// data_byte, region_end), one byte per request. A result leaves on the output
// channel (out_valid / out_ready, found, match_offset): found = 1 with the
// region offset of the first signature byte for the first full match of a
// region, or found = 0 with offset 0 when the region's last byte arrives
// without a match. Later bytes of a region that has already reported give no
// result. Configuration requests on the cfg channel are always taken at once;
// they should be issued only while the scanner is idle.
//
// Throughput is one byte per cycle while in_ready is high: the whole window
// compare is a single stage, one comparator per cell feeding an AND of the
// hit flags. A result enters the result buffer as its byte is accepted.
// When the receiver stalls, one result waits in the output register and a
// second can be parked in the skid register; in_ready drops only while the
// skid register is occupied. Reset empties the buffer, clears the region
// counter and loads the pattern registers with zero and the length with one.
module wildcard_byte_signature_scan_unit
	import wbss_pkg::*;
#(
	parameter int MAX_PATTERN_BYTES = 16,
	parameter int OFFSET_BITS       = 32
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0]   cfg_data,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [BYTE_BITS-1:0]       data_byte,
	input  logic                       region_end,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       found,
	output logic [OFFSET_OUT_BITS-1:0] match_offset
);

	// Configuration registers.
	logic [CFG_DATA_BITS-1:0] pattern_low_q;
	logic [CFG_DATA_BITS-1:0] pattern_high_q;
	logic [MASK_BITS-1:0]     care_mask_q;
	logic [LENGTH_BITS-1:0]   length_q;

	// Region state.
	logic [OFFSET_BITS-1:0] bytes_seen_q;
	logic                   reported_q;

	logic                   in_fire;
	logic [LENGTH_BITS-1:0] used_len;
	logic [OFFSET_BITS-1:0] seen_next;
	logic [OFFSET_BITS-1:0] diff;
	logic [63:0]            diff_ext;
	logic                   window_hit;
	logic                   match;
	logic                   res_push;
	logic                   buf_space;
	result_t                res;
	result_t                out_res;

	logic [8*SIG_BYTES-1:0] sig_all;

	logic [BYTE_BITS-1:0]   cell_in  [MAX_PATTERN_BYTES];
	logic [BYTE_BITS-1:0]   cell_out [MAX_PATTERN_BYTES];
	cell_cfg_t              cell_set [MAX_PATTERN_BYTES];
	logic [MAX_PATTERN_BYTES-1:0] cell_hit;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_low_q  <= '0;
			pattern_high_q <= '0;
			care_mask_q    <= '0;
			length_q       <= LENGTH_BITS'(1);
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_PATTERN_LOW:  pattern_low_q  <= cfg_data;
				CFG_PATTERN_HIGH: pattern_high_q <= cfg_data;
				CFG_CARE_MASK:    care_mask_q    <= cfg_data[MASK_BITS-1:0];
				CFG_LENGTH:       length_q       <= cfg_data[LENGTH_BITS-1:0];
				default:          ;
			endcase
		end
	end

	// A length of zero counts as one; any length beyond the window counts as the
	// window size.
	always_comb begin
		if (length_q == '0) begin
			used_len = LENGTH_BITS'(1);
		end else if (length_q > LENGTH_BITS'(MAX_PATTERN_BYTES)) begin
			used_len = LENGTH_BITS'(MAX_PATTERN_BYTES);
		end else begin
			used_len = length_q;
		end
	end

	assign sig_all = {pattern_high_q, pattern_low_q};
	assign in_fire = in_valid && in_ready;

	// Cell k holds the k-th newest byte, so it is checked against signature
	// byte used_len-1-k; cells past the signature length always hit.
	for (genvar k = 0; k < MAX_PATTERN_BYTES; k++) begin : g_cell
		logic [LENGTH_BITS-1:0]    sig_pos;
		logic [SIG_INDEX_BITS-1:0] sig_idx;

		assign sig_pos = used_len - LENGTH_BITS'(1) - LENGTH_BITS'(k);
		assign sig_idx = sig_pos[SIG_INDEX_BITS-1:0];

		assign cell_set[k].in_use   = LENGTH_BITS'(k) < used_len;
		assign cell_set[k].care     = care_mask_q[sig_idx];
		assign cell_set[k].expected = sig_all[sig_idx*BYTE_BITS +: BYTE_BITS];

		if (k == 0) begin : g_head
			assign cell_in[k] = data_byte;
		end else begin : g_link
			assign cell_in[k] = cell_out[k-1];
		end

		wbss_cell u_cell (
			.clk       (clk),
			.shift_en  (in_fire),
			.shift_in  (cell_in[k]),
			.setting   (cell_set[k]),
			.shift_out (cell_out[k]),
			.hit       (cell_hit[k])
		);
	end

	assign window_hit = &cell_hit;

	// The byte counter saturates at its maximum.
	assign seen_next = (bytes_seen_q == {OFFSET_BITS{1'b1}}) ?
		bytes_seen_q : bytes_seen_q + OFFSET_BITS'(1);

	// Window bytes older than the region cannot make a match, as a match
	// needs at least used_len bytes of the current region.
	assign match    = window_hit && (seen_next >= OFFSET_BITS'(used_len));
	assign diff     = seen_next - OFFSET_BITS'(used_len);
	assign diff_ext = 64'(diff);

	assign res.found  = match;
	assign res.offset = match ? diff_ext[OFFSET_OUT_BITS-1:0] : '0;
	assign res_push   = in_fire && !reported_q && (match || region_end);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bytes_seen_q <= '0;
			reported_q   <= 1'b0;
		end else if (in_fire) begin
			if (region_end) begin
				bytes_seen_q <= '0;
				reported_q   <= 1'b0;
			end else begin
				bytes_seen_q <= seen_next;
				reported_q   <= reported_q || match;
			end
		end
	end

	wbss_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_push),
		.push_data (res),
		.has_space (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_res)
	);

	assign in_ready     = buf_space;
	assign found        = out_res.found;
	assign match_offset = out_res.offset;

	// Once a region has reported, none of its later bytes may give a result.
	a_single_report: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && reported_q) |-> !res_push)
		else $error("second result pushed within one region");

	// A not-found result only comes from the last byte of a region.
	a_not_found_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && !res.found) |-> region_end)
		else $error("not-found result before the end of a region");

	// The input stalls only while results are actually waiting.
	a_stall_has_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with an empty output");

	// The last byte of a region leaves a fresh counter behind.
	a_region_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && region_end) |=> (bytes_seen_q == '0) && !reported_q)
		else $error("region state not cleared after its last byte");

endmodule

>>> tb/tb_wildcard_byte_signature_scan_unit.sv
`timescale 1ns / 100ps
// Self-checking testbench for wildcard_byte_signature_scan_unit: a driver, a receiver and a
// monitor with its own scan predictor, fed by directed regions and then random ones.
// Depends on wbss_pkg and the scanner RTL only.
module tb_wildcard_byte_signature_scan_unit
	import wbss_pkg::*;
;

	// A quiet stretch this long means the scanner has hung. The longest legal one is the
	// receiver hold plus the settling time, so this leaves a wide margin.
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 80;
	localparam int SETTLE_CYCLES  = 4;
	localparam int PHASE_ITEMS    = 150;
	localparam int BURST_REGIONS  = 40;
	localparam int REGION_MAX     = 48;

	// Register indexes that the scanner does not decode; writes to them must be ignored.
	localparam logic [CFG_INDEX_BITS-1:0] CFG_SPARE_INDEX = CFG_LENGTH + 1'b1;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_TOP_INDEX   = '1;

	typedef enum int {REGION_NOISE, REGION_PLANTED, REGION_BROKEN} region_kind_t;

	typedef struct {
		logic [BYTE_BITS-1:0] value;
		logic                 last;
	} scan_item_t;

	logic                       clk        = 1'b0;
	logic                       arst_n     = 1'b0;
	logic                       cfg_valid  = 1'b0;
	logic                       cfg_ready;
	logic [CFG_INDEX_BITS-1:0]  cfg_index  = '0;
	logic [CFG_DATA_BITS-1:0]   cfg_data   = '0;
	logic                       in_valid   = 1'b0;
	logic                       in_ready;
	logic [BYTE_BITS-1:0]       data_byte  = '0;
	logic                       region_end = 1'b0;
	logic                       out_valid;
	logic                       out_ready  = 1'b0;
	logic                       found;
	logic [OFFSET_OUT_BITS-1:0] match_offset;

	wildcard_byte_signature_scan_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.region_end   (region_end),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.match_offset (match_offset)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Bytes waiting to be offered, and the scan reports the predictor has promised.
	scan_item_t pending_bytes [$];
	result_t    awaited_reports [$];
	scan_item_t next_item;
	result_t    oldest_report;

	int item_count     = 0;
	int mismatch_count = 0;
	int send_idle_pct  = 0;
	int recv_idle_pct  = 0;
	int hold_asked     = 0;
	int hold_served    = 0;
	int hold_left      = 0;

	// Shadow copy of the scanner's registers, at their reset values.
	logic [CFG_DATA_BITS-1:0]   sig_low      = '0;
	logic [CFG_DATA_BITS-1:0]   sig_high     = '0;
	logic [MASK_BITS-1:0]       care_bits    = '0;
	logic [LENGTH_BITS-1:0]     length_field = 5'd1;

	// Shadow copy of the region state: newest byte in entry 0.
	logic [BYTE_BITS-1:0]       window_q [SIG_BYTES];
	logic [OFFSET_OUT_BITS-1:0] seen_count;
	logic                       region_reported;

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("[%0t] mismatch: %s", $time, what);
	endtask

	task automatic clear_region_state();
		foreach (window_q[i]) window_q[i] = '0;
		seen_count = '0;
		region_reported = 1'b0;
	endtask

	// A length of zero is treated as one, anything past the window as the full window.
	function automatic int active_length();
		if (length_field == 0) return 1;
		if (length_field > SIG_BYTES) return SIG_BYTES;
		return int'(length_field);
	endfunction

	function automatic logic [BYTE_BITS-1:0] signature_byte_at(input int i);
		if (i < 8) return sig_low[(i % 8) * BYTE_BITS +: BYTE_BITS];
		return sig_high[(i % 8) * BYTE_BITS +: BYTE_BITS];
	endfunction

	// Advances the shadow region by one byte and queues the report it causes, if any.
	task automatic scan_byte(input logic [BYTE_BITS-1:0] value, input logic last);
		int      len;
		bit      hit;
		result_t report;
		len = active_length();
		for (int i = SIG_BYTES - 1; i > 0; i--) window_q[i] = window_q[i - 1];
		window_q[0] = value;
		// The region counter saturates rather than wrapping.
		if (seen_count != '1) seen_count++;
		hit = (seen_count >= len);
		// Signature byte i lines up with the byte taken len-1-i requests ago.
		for (int i = 0; i < len; i++) begin
			if (care_bits[i] && window_q[len - 1 - i] != signature_byte_at(i)) hit = 1'b0;
		end
		// Only the first match of a region is reported; once it has been, even the
		// region's last byte stays silent.
		if (!region_reported) begin
			if (hit) begin
				report.found = 1'b1;
				report.offset = seen_count - len;
				awaited_reports.push_back(report);
				region_reported = 1'b1;
			end else if (last) begin
				report.found = 1'b0;
				report.offset = '0;
				awaited_reports.push_back(report);
			end
		end
		if (last) clear_region_state();
	endtask

	// Driver: a new request is offered only once the current one has been taken, so
	// valid and the payload hold steady while the scanner stalls.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (pending_bytes.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
				next_item = pending_bytes.pop_front();
				in_valid <= 1'b1;
				data_byte <= next_item.value;
				region_end <= next_item.last;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure, plus a long hold whenever the stimulus asks for
	// one, so that the result buffer fills and the scanner has to stall its input.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			hold_left <= 0;
			hold_served <= 0;
		end else if (hold_left != 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_served != hold_asked) begin
			out_ready <= 1'b0;
			hold_left <= HOLD_CYCLES;
			hold_served <= hold_served + 1;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor: everything is sampled at the rising edge, before the driver's updates land.
	// The result is checked before this edge's byte is predicted, since a result never
	// leaves in the cycle its byte is taken.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_PATTERN_LOW:  sig_low = cfg_data;
					CFG_PATTERN_HIGH: sig_high = cfg_data;
					CFG_CARE_MASK:    care_bits = cfg_data[MASK_BITS-1:0];
					CFG_LENGTH:       length_field = cfg_data[LENGTH_BITS-1:0];
					default: ;
				endcase
			end
			if (out_valid && out_ready) begin
				if (awaited_reports.size() == 0) begin
					report_mismatch($sformatf("unexpected result found=%0b offset=%0d",
						found, match_offset));
				end else begin
					oldest_report = awaited_reports.pop_front();
					if (found !== oldest_report.found)
						report_mismatch($sformatf("found %0b, expected %0b",
							found, oldest_report.found));
					if (match_offset !== oldest_report.offset)
						report_mismatch($sformatf("match_offset %0d, expected %0d",
							match_offset, oldest_report.offset));
				end
			end
			if (in_valid && in_ready) scan_byte(data_byte, region_end);
		end
	end

	task automatic queue_byte(input logic [BYTE_BITS-1:0] value, input logic last);
		pending_bytes.push_back('{value: value, last: last});
		item_count++;
	endtask

	// Waits until every queued byte has been taken and every promised report has arrived.
	task automatic wait_drained();
		do @(negedge clk);
		while (pending_bytes.size() != 0 || in_valid || awaited_reports.size() != 0);
	endtask

	// As above, then lets the last silent bytes clear the compare stage.
	task automatic wait_idle();
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_BITS-1:0] index,
			input logic [CFG_DATA_BITS-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Returns only once the monitor's shadow registers hold the new setting.
	task automatic load_setting(input logic [CFG_DATA_BITS-1:0] low, high, care, length);
		write_register(CFG_PATTERN_LOW, low);
		write_register(CFG_PATTERN_HIGH, high);
		write_register(CFG_CARE_MASK, care);
		write_register(CFG_LENGTH, length);
		@(negedge clk);
	endtask

	// Unused upper bits are filled at random so that the scanner's masking is exercised
	// too. Lengths of zero and past the window turn up now and then.
	task automatic load_random_setting();
		logic [CFG_DATA_BITS-1:0] care;
		logic [CFG_DATA_BITS-1:0] length;
		int                       pick;
		care = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 30) care[MASK_BITS-1:0] = '1;
		else if (pick < 45) care[MASK_BITS-1:0] = '0;
		else if (pick < 60) care[MASK_BITS-1:0] = care[MASK_BITS-1:0] & MASK_BITS'($urandom);
		length = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 80) length[LENGTH_BITS-1:0] = LENGTH_BITS'($urandom_range(SIG_BYTES, 1));
		else if (pick < 90) length[LENGTH_BITS-1:0] = '0;
		else length[LENGTH_BITS-1:0] = LENGTH_BITS'($urandom_range(31, SIG_BYTES + 1));
		load_setting({$urandom, $urandom}, {$urandom, $urandom}, care, length);
	endtask

	// Builds one region of random bytes. A planted region that is long enough carries the
	// signature at a random place, with random bytes in its wildcard positions; a broken one
	// has a single bit flipped in that copy, in a compared byte where there is one.
	task automatic queue_region(input int rlen, input region_kind_t kind, input bit pause_midway);
		logic [BYTE_BITS-1:0] region_bytes [REGION_MAX];
		int                   len;
		int                   pos;
		int                   pick;
		len = active_length();
		for (int i = 0; i < rlen; i++) region_bytes[i] = BYTE_BITS'($urandom);
		if (kind != REGION_NOISE && rlen >= len) begin
			pos = $urandom_range(rlen - len, 0);
			for (int i = 0; i < len; i++) begin
				if (care_bits[i]) region_bytes[pos + i] = signature_byte_at(i);
			end
			if (kind == REGION_BROKEN) begin
				pick = $urandom_range(len - 1, 0);
				for (int t = 0; t < len && !care_bits[pick]; t++) pick = (pick + 1) % len;
				region_bytes[pos + pick] ^= 8'd1 << $urandom_range(7, 0);
			end
		end
		for (int i = 0; i < rlen; i++) begin
			// The sender stops halfway through the region until the scanner has gone quiet.
			if (pause_midway && i == rlen / 2) wait_drained();
			queue_byte(region_bytes[i], i == rlen - 1);
		end
	endtask

	// Watchdog: ends the run if nothing at all is accepted for too long.
	initial begin : watchdog
		int quiet_cycles;
		quiet_cycles = 0;
		wait (arst_n);
		while (quiet_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
		end
		$display("tb_wildcard_byte_signature_scan_unit: FAIL");
		$finish;
	end

	initial begin : stimulus
		int           phase_start;
		int           regions;
		int           rlen;
		region_kind_t kind;
		clear_region_state();
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		send_idle_pct = 22;
		recv_idle_pct = 57;

		// Reset setting: a one-byte signature with no compared bytes, so the first byte
		// matches at offset 0 and the rest of the region, its last byte included, is silent.
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		wait_idle();

		// Signature DE AD ?? EF. Writes to undecoded indexes must change nothing.
		load_setting(64'h0000_0000_EF00_ADDE, '1, 64'h000B, 64'd4);
		write_register(CFG_SPARE_INDEX, '1);
		write_register(CFG_TOP_INDEX, '0);
		// Region shorter than the signature: not found.
		queue_byte(8'hDE, 1'b0);
		queue_byte(8'hAD, 1'b0);
		queue_byte(8'h00, 1'b1);
		// False start, then a match that completes on the region's last byte.
		queue_byte(8'hDE, 1'b0);
		queue_byte(8'hDE, 1'b0);
		queue_byte(8'hAD, 1'b0);
		queue_byte(8'h77, 1'b0);
		queue_byte(8'hEF, 1'b1);
		// Match at offset 0 followed by a byte that must give nothing.
		queue_byte(8'hDE, 1'b0);
		queue_byte(8'hAD, 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(8'hEF, 1'b0);
		queue_byte(8'h01, 1'b1);
		wait_idle();

		// Length zero behaves as one: single compared byte FF.
		load_setting(64'h0000_0000_0000_00FF, '0, 64'hFFFF, 64'd0);
		queue_byte(8'h00, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b1);

		// Random part in three idling regimes, three settings each. The first setting is
		// the all-ones extreme (length field 31, taken as the full window), a later one
		// the all-zero pattern and mask with length one.
		for (int mode = 0; mode < 3; mode++) begin
			for (int s = 0; s < 3; s++) begin
				wait_idle();
				send_idle_pct = (mode == 0) ? 22 : (mode == 1) ? 57 : 0;
				recv_idle_pct = (mode == 0) ? 57 : (mode == 1) ? 22 : 0;
				if (mode == 0 && s == 0) load_setting('1, '1, '1, '1);
				else if (mode == 1 && s == 1) load_setting('0, '0, '0, 64'd1);
				else load_random_setting();
				// A burst of one-byte regions, each giving a report, against a held receiver.
				if (mode == 2 && s == 0) begin
					hold_asked++;
					for (int r = 0; r < BURST_REGIONS; r++)
						queue_byte(BYTE_BITS'($urandom), 1'b1);
				end
				phase_start = item_count;
				regions = 0;
				while (item_count - phase_start < PHASE_ITEMS) begin
					rlen = ($urandom_range(99) < 70) ? $urandom_range(20, 1)
						: $urandom_range(REGION_MAX, 21);
					case ($urandom_range(99) / 25)
						0, 1: kind = REGION_PLANTED;
						2:    kind = REGION_BROKEN;
						default: kind = REGION_NOISE;
					endcase
					queue_region(rlen, kind, regions == 3);
					regions++;
				end
			end
		end

		wait_idle();
		if (mismatch_count == 0)
			$display("tb_wildcard_byte_signature_scan_unit: PASS");
		else
			$display("tb_wildcard_byte_signature_scan_unit: FAIL");
		$finish;
	end

endmodule
